// File: rtl/core/ad_pkg.sv
// ad_pkg: shared types and constants of the array deque
// action and status codes, field widths, default depth
// no dependencies
package ad_pkg;

	localparam int DEPTH_DEF = 128;
	localparam int DATA_W    = 32;
	localparam int ACTION_W  = 3;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_QUERY      = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

endpackage

// File: rtl/core/array_deque.sv
// array_deque: double-ended queue in a linear, non-wrapping store
// depends on ad_pkg and ad_store
//
// Usage:
//   Input channel (in_valid/in_ready) carries one action per beat: push
//   front, push back, pop front, pop back or query, with a value for pushes.
//   Output channel (out_valid/out_ready) returns one result beat per input
//   beat: status, front and back elements (-1 when empty), count, is_empty.
//   A push at the front is refused while the head sits at index 0, a push
//   at the back while the tail sits at the last index; pushes into an empty
//   deque land at index 0, popping the last element returns both indices
//   to 0.
// Pipeline and throughput:
//   a beat is held in the input register, processed against the memory and
//   registered into the result register, which drives the output. One beat
//   per cycle is sustained while out_ready is high; the memory's single
//   write port and two registered read ports are used at most once per beat.
// Reset: arst_n clears the indices, the empty flag and both valid flags;
//   the memory keeps its contents and no entry is output before being written.
// Stall: while a result waits on out_ready the input register holds its
//   beat and in_ready drops once it is full; nothing is lost or repeated.
module array_deque #(
	parameter int DEPTH = ad_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ad_pkg::ACTION_W-1:0]         action,
	input  logic signed [ad_pkg::DATA_W-1:0]    value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ad_pkg::STATUS_W-1:0]         status,
	output logic signed [ad_pkg::DATA_W-1:0]    front_value,
	output logic signed [ad_pkg::DATA_W-1:0]    back_value,
	output logic [ad_pkg::COUNT_W-1:0]          count,
	output logic                                is_empty
);
	import ad_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	typedef enum logic [1:0] {
		SRC_MEM   = 2'd0,
		SRC_NEW   = 2'd1,
		SRC_EMPTY = 2'd2
	} src_t;

	// input register
	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [DATA_W-1:0]   value_s1;

	// deque state
	logic [IW-1:0] head_q, tail_q;
	logic          holds_q;

	// result register
	logic                out_valid_q;
	status_t             status_q;
	logic [COUNT_W-1:0]  count_q;
	logic                empty_q;
	src_t                fsrc_q, bsrc_q;
	logic [DATA_W-1:0]   new_q;
	logic [DATA_W-1:0]   rd_front, rd_back;

	// next-state logic
	logic [IW-1:0] head_n, tail_n, waddr;
	logic          holds_n, we, adv;
	status_t       status_n;
	logic [CW-1:0] diff;
	logic [COUNT_W-1:0] count_n;
	src_t          fsrc_n, bsrc_n;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		holds_n  = holds_q;
		status_n = ST_DONE;
		we       = 1'b0;
		waddr    = head_q;
		case (action_s1)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (!holds_q) begin
					head_n  = '0;
					tail_n  = '0;
					holds_n = 1'b1;
					we      = 1'b1;
					waddr   = '0;
				end else if (action_s1 == ACT_PUSH_FRONT) begin
					if (head_q != '0) begin
						head_n = head_q - IW'(1);
						we     = 1'b1;
						waddr  = head_q - IW'(1);
					end else begin
						status_n = ST_OVERFLOW;
					end
				end else begin
					if (tail_q != LAST_IDX) begin
						tail_n = tail_q + IW'(1);
						we     = 1'b1;
						waddr  = tail_q + IW'(1);
					end else begin
						status_n = ST_OVERFLOW;
					end
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (!holds_q) begin
					status_n = ST_UNDERFLOW;
				end else if (head_q == tail_q) begin
					holds_n = 1'b0;
					head_n  = '0;
					tail_n  = '0;
				end else if (action_s1 == ACT_POP_FRONT) begin
					head_n = head_q + IW'(1);
				end else begin
					tail_n = tail_q - IW'(1);
				end
			end
			default: begin
				// query and unused codes leave the state alone
			end
		endcase
	end

	always_comb begin
		diff    = CW'(tail_n) - CW'(head_n) + CW'(1);
		count_n = holds_n ? diff[COUNT_W-1:0] : '0;
		// a freshly written entry is not yet readable, take it from the beat
		if (!holds_n) begin
			fsrc_n = SRC_EMPTY;
			bsrc_n = SRC_EMPTY;
		end else begin
			fsrc_n = (we && waddr == head_n) ? SRC_NEW : SRC_MEM;
			bsrc_n = (we && waddr == tail_n) ? SRC_NEW : SRC_MEM;
		end
	end

	ad_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we && adv),
		.waddr   (waddr),
		.wdata   (value_s1),
		.re      (adv),
		.raddr_a (head_n),
		.raddr_b (tail_n),
		.rdata_a (rd_front),
		.rdata_b (rd_back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			value_s1  <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			holds_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				holds_q <= holds_n;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= status_n;
			count_q  <= count_n;
			empty_q  <= !holds_n;
			fsrc_q   <= fsrc_n;
			bsrc_q   <= bsrc_n;
			new_q    <= value_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign count       = count_q;
	assign is_empty    = empty_q;
	assign front_value = (fsrc_q == SRC_EMPTY) ? EMPTY_MARK :
	                     (fsrc_q == SRC_NEW)   ? new_q : rd_front;
	assign back_value  = (bsrc_q == SRC_EMPTY) ? EMPTY_MARK :
	                     (bsrc_q == SRC_NEW)   ? new_q : rd_back;

	// an empty deque parks both indices at zero
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!holds_q |-> (head_q == '0 && tail_q == '0))
		else $error("empty deque with nonzero index");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		holds_q |-> (head_q <= tail_q))
		else $error("head index past tail index");

	// a stalled result freezes the deque state
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(head_q) && $stable(tail_q)
		&& $stable(holds_q)))
		else $error("deque state moved during output stall");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_UNDERFLOW) |-> (empty_q && count_q == '0))
		else $error("underflow reported on a non-empty deque");

endmodule

// File: rtl/core/ad_store.sv
// ad_store: element memory of the array deque
// one write port, two registered read ports with a shared read enable
// depends on ad_pkg
module ad_store #(
	parameter int DEPTH = ad_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [ad_pkg::DATA_W-1:0]  wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr_a,
	input  logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic [ad_pkg::DATA_W-1:0]  rdata_a,
	output logic [ad_pkg::DATA_W-1:0]  rdata_b
);
	import ad_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read returns the old entry on a same-address write; caller bypasses
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
